/* rtl/tch_pkg.sv */
package tch_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int STEP_W = 5;

    // Q2.30 constants; DEG_Q16 is a Q16 scale factor and FULL_TURN an integer
    localparam logic signed [33:0] GAIN_Q30    = 34'sh026DD3B6A;
    localparam logic signed [33:0] HALF_PI_Q30 = 34'sh06487ED51;
    localparam logic signed [33:0] PI_Q30      = 34'sh0C90FDAA2;
    localparam logic signed [31:0] DEG_Q16     = 32'sd480631834;
    localparam int FULL_TURN = 46080;

    // sin/cos datapath width (values stay within about +-1.7 in Q2.30)
    localparam int SC_W = 34;
    // vectoring datapath width: xH, yH are Q.30 below 2^47, growth 1.65x
    localparam int V_W  = 63;

    typedef logic signed [SC_W-1:0] t_sc;
    typedef logic signed [V_W-1:0]  t_vec;

    // atan(2^-i) in Q2.30, truncated
    function automatic t_sc atan_q30(input logic [STEP_W-1:0] i);
        case (i)
            5'd0:  atan_q30 = 34'sh03243F6A8;
            5'd1:  atan_q30 = 34'sh01DAC6705;
            5'd2:  atan_q30 = 34'sh00FADBAFC;
            5'd3:  atan_q30 = 34'sh007F56EA6;
            5'd4:  atan_q30 = 34'sh003FEAB76;
            5'd5:  atan_q30 = 34'sh001FFD55B;
            5'd6:  atan_q30 = 34'sh000FFFAAA;
            5'd7:  atan_q30 = 34'sh0007FFF55;
            5'd8:  atan_q30 = 34'sh0003FFFEA;
            5'd9:  atan_q30 = 34'sh0001FFFFD;
            5'd10: atan_q30 = 34'sh0000FFFFF;
            5'd11: atan_q30 = 34'sh00007FFFF;
            5'd12: atan_q30 = 34'sh00003FFFF;
            5'd13: atan_q30 = 34'sh00001FFFF;
            5'd14: atan_q30 = 34'sh00000FFFF;
            5'd15: atan_q30 = 34'sh000007FFF;
            5'd16: atan_q30 = 34'sh000003FFF;
            5'd17: atan_q30 = 34'sh000001FFF;
            5'd18: atan_q30 = 34'sh000000FFF;
            5'd19: atan_q30 = 34'sh0000007FF;
            5'd20: atan_q30 = 34'sh0000003FF;
            5'd21: atan_q30 = 34'sh0000001FF;
            5'd22: atan_q30 = 34'sh0000000FF;
            5'd23: atan_q30 = 34'sh00000007F;
            default: atan_q30 = '0;
        endcase
    endfunction

endpackage

/* rtl/tilt_compensated_heading.sv */
// Pipeline from input beat to output beat: input fold, rotation cells, projection stages,
// vectoring cells, scaling.
// Throughput: one beat per cycle; the whole pipeline advances when the output is not stalled.
// Reset clears the valid bits of every stage; data registers are not reset.
module tilt_compensated_heading import tch_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [15:0] i_field_x,
    input  logic signed [15:0] i_field_y,
    input  logic signed [15:0] i_field_z,
    input  logic signed [15:0] i_pitch_angle,
    input  logic signed [15:0] i_roll_angle,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [15:0]        o_heading
);
    localparam int NS  = CORDIC_STEPS;
    localparam int NP  = 8;
    localparam int NF  = 3;
    localparam int LAT = 1 + NS + NP + NS + NF;

    logic           w_en;
    logic [LAT-1:0] r_vld;

    // pipeline moves whenever the output slot is free or being taken
    assign w_en    = !(o_valid && i_stall);
    assign o_stall = !w_en;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else if (w_en) r_vld <= {r_vld[LAT-2:0], i_valid};
    end

    // field carry line along the rotation chain
    logic signed [15:0] r_fx [NS+1];
    logic signed [15:0] r_fy [NS+1];
    logic signed [15:0] r_fz [NS+1];

    // input stage: quadrant fold of both angles
    t_sc  xp [NS+1], yp [NS+1], zp [NS+1], xr [NS+1], yr [NS+1], zr [NS+1];
    logic r_negp [NS+1];
    logic r_negr [NS+1];
    t_sc  n_zp0, n_zr0;
    logic n_negp, n_negr;
    t_sc  r_zp0, r_zr0;

    always_comb begin
        n_zp0  = t_sc'(i_pitch_angle) <<< 17;
        n_zr0  = t_sc'(i_roll_angle) <<< 17;
        n_negp = 1'b0;
        n_negr = 1'b0;
        if (n_zp0 > HALF_PI_Q30) begin
            n_zp0 = n_zp0 - PI_Q30; n_negp = 1'b1;
        end else if (n_zp0 < -HALF_PI_Q30) begin
            n_zp0 = n_zp0 + PI_Q30; n_negp = 1'b1;
        end
        if (n_zr0 > HALF_PI_Q30) begin
            n_zr0 = n_zr0 - PI_Q30; n_negr = 1'b1;
        end else if (n_zr0 < -HALF_PI_Q30) begin
            n_zr0 = n_zr0 + PI_Q30; n_negr = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_zp0 <= n_zp0; r_zr0 <= n_zr0;
            r_negp[0] <= n_negp; r_negr[0] <= n_negr;
            r_fx[0] <= i_field_x; r_fy[0] <= i_field_y; r_fz[0] <= i_field_z;
        end
    end

    assign xp[0] = GAIN_Q30; assign yp[0] = '0; assign zp[0] = r_zp0;
    assign xr[0] = GAIN_Q30; assign yr[0] = '0; assign zr[0] = r_zr0;

    // rotation chain
    for (genvar g = 0; g < NS; g++) begin : g_rot
        tch_rot_cell u_cell (
            .i_clk, .i_en(w_en), .i_step(STEP_W'(g)),
            .i_xp(xp[g]), .i_yp(yp[g]), .i_zp(zp[g]),
            .i_xr(xr[g]), .i_yr(yr[g]), .i_zr(zr[g]),
            .o_xp(xp[g+1]), .o_yp(yp[g+1]), .o_zp(zp[g+1]),
            .o_xr(xr[g+1]), .o_yr(yr[g+1]), .o_zr(zr[g+1])
        );
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_fx[g+1] <= r_fx[g]; r_fy[g+1] <= r_fy[g]; r_fz[g+1] <= r_fz[g];
                r_negp[g+1] <= r_negp[g]; r_negr[g+1] <= r_negr[g];
            end
        end
    end

    // projection stage 1: sign fix of sin/cos
    t_sc r_sp, r_cp, r_sr, r_cr;
    logic signed [15:0] r1_fx, r1_fy, r1_fz;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cp <= r_negp[NS] ? -xp[NS] : xp[NS];
            r_sp <= r_negp[NS] ? -yp[NS] : yp[NS];
            r_cr <= r_negr[NS] ? -xr[NS] : xr[NS];
            r_sr <= r_negr[NS] ? -yr[NS] : yr[NS];
            r1_fx <= r_fx[NS]; r1_fy <= r_fy[NS]; r1_fz <= r_fz[NS];
        end
    end

    // stages 2-4: sp*sr and sp*cr, split in 17-bit partial products
    logic signed [16:0] w_sp_hi, w_sr_hi, w_cr_hi;
    logic        [16:0] w_sp_lo, w_sr_lo, w_cr_lo;
    assign w_sp_hi = r_sp[33:17]; assign w_sp_lo = r_sp[16:0];
    assign w_sr_hi = r_sr[33:17]; assign w_sr_lo = r_sr[16:0];
    assign w_cr_hi = r_cr[33:17]; assign w_cr_lo = r_cr[16:0];

    logic signed [67:0] r_pa_hh, r_pa_hl, r_pa_lh, r_pa_ll;
    logic signed [67:0] r_pb_hh, r_pb_hl, r_pb_lh, r_pb_ll;
    t_sc r2_cp, r2_sr, r2_cr;
    logic signed [15:0] r2_fx, r2_fy, r2_fz;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pa_hh <= 68'(w_sp_hi * w_sr_hi) <<< 34;
            r_pa_hl <= 68'(w_sp_hi * $signed({1'b0, w_sr_lo})) <<< 17;
            r_pa_lh <= 68'($signed({1'b0, w_sp_lo}) * w_sr_hi) <<< 17;
            r_pa_ll <= 68'($signed({1'b0, w_sp_lo}) * $signed({1'b0, w_sr_lo}));
            r_pb_hh <= 68'(w_sp_hi * w_cr_hi) <<< 34;
            r_pb_hl <= 68'(w_sp_hi * $signed({1'b0, w_cr_lo})) <<< 17;
            r_pb_lh <= 68'($signed({1'b0, w_sp_lo}) * w_cr_hi) <<< 17;
            r_pb_ll <= 68'($signed({1'b0, w_sp_lo}) * $signed({1'b0, w_cr_lo}));
            r2_cp <= r_cp; r2_sr <= r_sr; r2_cr <= r_cr;
            r2_fx <= r1_fx; r2_fy <= r1_fy; r2_fz <= r1_fz;
        end
    end

    logic signed [67:0] r_pa, r_pb;
    t_sc r3_cp, r3_sr, r3_cr;
    logic signed [15:0] r3_fx, r3_fy, r3_fz;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pa <= r_pa_hh + r_pa_hl + r_pa_lh + r_pa_ll;
            r_pb <= r_pb_hh + r_pb_hl + r_pb_lh + r_pb_ll;
            r3_cp <= r2_cp; r3_sr <= r2_sr; r3_cr <= r2_cr;
            r3_fx <= r2_fx; r3_fy <= r2_fy; r3_fz <= r2_fz;
        end
    end

    t_sc r_ss, r_sc;
    t_sc r4_cp, r4_sr, r4_cr;
    logic signed [15:0] r4_fx, r4_fy, r4_fz;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ss <= SC_W'(r_pa >>> 30);
            r_sc <= SC_W'(r_pb >>> 30);
            r4_cp <= r3_cp; r4_sr <= r3_sr; r4_cr <= r3_cr;
            r4_fx <= r3_fx; r4_fy <= r3_fy; r4_fz <= r3_fz;
        end
    end

    // stage 5: five field products (16 x 34)
    logic signed [50:0] r_m0, r_m1, r_m2, r_m3, r_m4;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m0 <= 51'(r4_fx * r4_cp);
            r_m1 <= 51'(r4_fy * r_ss);
            r_m2 <= 51'(r4_fz * r_sc);
            r_m3 <= 51'(r4_fy * r4_cr);
            r_m4 <= 51'(r4_fz * r4_sr);
        end
    end

    // stage 6: sums
    t_vec r_xh, r_yh;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_xh <= t_vec'(r_m0) + t_vec'(r_m1) + t_vec'(r_m2);
            r_yh <= t_vec'(r_m3) - t_vec'(r_m4);
        end
    end

    // stage 7: negate y, zero test
    t_vec r_ny, r_nx;
    logic r_z7;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_nx <= r_xh;
            r_ny <= -r_yh;
            r_z7 <= (r_xh == '0) && (r_yh == '0);
        end
    end

    // stage 8: left half-plane pre-rotation
    t_vec vx [NS+1], vy [NS+1];
    t_sc  vz [NS+1];
    logic vzero [NS+1];
    t_vec r_vx0, r_vy0;
    t_sc  r_vz0;
    logic r_zero0;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_zero0 <= r_z7;
            if (r_nx < 0) begin
                if (r_ny >= 0) begin
                    r_vx0 <= r_ny; r_vy0 <= -r_nx; r_vz0 <= HALF_PI_Q30;
                end else begin
                    r_vx0 <= -r_ny; r_vy0 <= r_nx; r_vz0 <= -HALF_PI_Q30;
                end
            end else begin
                r_vx0 <= r_nx; r_vy0 <= r_ny; r_vz0 <= '0;
            end
        end
    end
    assign vx[0] = r_vx0; assign vy[0] = r_vy0; assign vz[0] = r_vz0;
    assign vzero[0] = r_zero0;

    // vectoring chain
    for (genvar g = 0; g < NS; g++) begin : g_vec
        tch_vec_cell u_cell (
            .i_clk, .i_en(w_en), .i_step(STEP_W'(g)),
            .i_x(vx[g]), .i_y(vy[g]), .i_z(vz[g]), .i_zero(vzero[g]),
            .o_x(vx[g+1]), .o_y(vy[g+1]), .o_z(vz[g+1]), .o_zero(vzero[g+1])
        );
    end

    // scaling: z * DEG_Q16 (34 x 32) split in two partial products
    logic signed [16:0] w_zh;
    logic        [16:0] w_zl;
    assign w_zh = vz[NS][33:17];
    assign w_zl = vz[NS][16:0];
    logic signed [65:0] r_qh, r_ql;
    logic r_zf1, r_zf2;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_qh  <= 66'(w_zh * DEG_Q16) <<< 17;
            r_ql  <= 66'($signed({1'b0, w_zl}) * DEG_Q16);
            r_zf1 <= vzero[NS];
        end
    end

    logic signed [65:0] w_hp;
    logic signed [19:0] r_h;
    assign w_hp = r_qh + r_ql + (66'sd1 <<< 45);
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_h   <= 20'(w_hp >>> 46);
            r_zf2 <= r_zf1;
        end
    end

    // wrap into one turn; a zero vector gives heading 0
    logic [15:0] r_out;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (r_zf2) r_out <= '0;
            else if (r_h < 0) r_out <= 16'(r_h + 20'(FULL_TURN));
            else if (r_h >= 20'(FULL_TURN)) r_out <= 16'(r_h - 20'(FULL_TURN));
            else r_out <= r_h[15:0];
        end
    end
    assign o_heading = r_out;
endmodule

/* rtl/tch_rot_cell.sv */
// One rotation-mode CORDIC iteration for pitch and roll side by side
module tch_rot_cell import tch_pkg::*; (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [STEP_W-1:0] i_step,
    input  t_sc               i_xp, i_yp, i_zp,
    input  t_sc               i_xr, i_yr, i_zr,
    output t_sc               o_xp, o_yp, o_zp,
    output t_sc               o_xr, o_yr, o_zr
);
    t_sc n_xp, n_yp, n_zp, n_xr, n_yr, n_zr;
    t_sc r_xp, r_yp, r_zp, r_xr, r_yr, r_zr;
    t_sc w_at;

    always_comb begin
        w_at = atan_q30(i_step);
        if (i_zp >= 0) begin
            n_xp = i_xp - (i_yp >>> i_step);
            n_yp = i_yp + (i_xp >>> i_step);
            n_zp = i_zp - w_at;
        end else begin
            n_xp = i_xp + (i_yp >>> i_step);
            n_yp = i_yp - (i_xp >>> i_step);
            n_zp = i_zp + w_at;
        end
        if (i_zr >= 0) begin
            n_xr = i_xr - (i_yr >>> i_step);
            n_yr = i_yr + (i_xr >>> i_step);
            n_zr = i_zr - w_at;
        end else begin
            n_xr = i_xr + (i_yr >>> i_step);
            n_yr = i_yr - (i_xr >>> i_step);
            n_zr = i_zr + w_at;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_xp <= n_xp; r_yp <= n_yp; r_zp <= n_zp;
            r_xr <= n_xr; r_yr <= n_yr; r_zr <= n_zr;
        end
    end

    assign o_xp = r_xp; assign o_yp = r_yp; assign o_zp = r_zp;
    assign o_xr = r_xr; assign o_yr = r_yr; assign o_zr = r_zr;
endmodule

/* rtl/tch_vec_cell.sv */
// One vectoring-mode CORDIC iteration
module tch_vec_cell import tch_pkg::*; (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [STEP_W-1:0] i_step,
    input  t_vec              i_x, i_y,
    input  t_sc               i_z,
    input  logic              i_zero,
    output t_vec              o_x, o_y,
    output t_sc               o_z,
    output logic              o_zero
);
    t_vec n_x, n_y, r_x, r_y;
    t_sc  n_z, r_z;
    logic r_zero;

    always_comb begin
        if (i_y > 0) begin
            n_x = i_x + (i_y >>> i_step);
            n_y = i_y - (i_x >>> i_step);
            n_z = i_z + atan_q30(i_step);
        end else begin
            n_x = i_x - (i_y >>> i_step);
            n_y = i_y + (i_x >>> i_step);
            n_z = i_z - atan_q30(i_step);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= n_x; r_y <= n_y; r_z <= n_z; r_zero <= i_zero;
        end
    end

    assign o_x = r_x; assign o_y = r_y; assign o_z = r_z; assign o_zero = r_zero;
endmodule

/* tb/tilt_compensated_heading_checker.sv */
`timescale 1ns / 100ps

module tilt_compensated_heading_checker import tch_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_stall_in,
    input  logic signed [15:0] i_field_x,
    input  logic signed [15:0] i_field_y,
    input  logic signed [15:0] i_field_z,
    input  logic signed [15:0] i_pitch_angle,
    input  logic signed [15:0] i_roll_angle,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [15:0]        i_heading,
    output int                 o_errors,
    output int                 o_pending,
    output int                 o_headings_seen
);

    localparam longint ATAN_TBL [24] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
        64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
        64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
        64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
        64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};

    logic [15:0] heading_q[$];

    function automatic int n_steps();
        return (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
    endfunction

    // rotation CORDIC: Q3.13 angle code -> sin, cos in Q2.30
    function automatic void rotate(input longint code, output longint s, output longint c);
        longint z, x, y, dx, dy;
        bit     flip;
        z = code * 131072;
        x = longint'(GAIN_Q30);
        y = 0;
        flip = 0;
        if (z > longint'(HALF_PI_Q30)) begin
            z -= longint'(PI_Q30); flip = 1;
        end else if (z < -longint'(HALF_PI_Q30)) begin
            z += longint'(PI_Q30); flip = 1;
        end
        for (int i = 0; i < n_steps(); i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= ATAN_TBL[i];
            end else begin
                x += dx; y -= dy; z += ATAN_TBL[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    // vectoring CORDIC: angle of (x, y) in Q2.30
    function automatic longint vector_angle(input longint y, input longint x);
        longint z, t, dx, dy;
        z = 0;
        if (x < 0) begin
            if (y >= 0) begin
                t = x; x = y; y = -t; z = longint'(HALF_PI_Q30);
            end else begin
                t = x; x = -y; y = t; z = -longint'(HALF_PI_Q30);
            end
        end
        for (int i = 0; i < n_steps(); i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x += dx; y -= dy; z += ATAN_TBL[i];
            end else begin
                x -= dx; y += dy; z -= ATAN_TBL[i];
            end
        end
        return z;
    endfunction

    function automatic logic [15:0] predict_heading(input longint fx, input longint fy,
                                                    input longint fz, input longint p,
                                                    input longint r);
        longint sp, cp, sr, cr, xh, yh, z, h;
        rotate(p, sp, cp);
        rotate(r, sr, cr);
        xh = fx * cp + fy * ((sp * sr) >>> 30) + fz * ((sp * cr) >>> 30);
        yh = fy * cr - fz * sr;
        if (xh == 0 && yh == 0) return '0;
        z = vector_angle(-yh, xh);
        h = (z * longint'(DEG_Q16) + (64'sd1 <<< 45)) >>> 46;
        if (h < 0) h += FULL_TURN;
        if (h >= FULL_TURN) h -= FULL_TURN;
        return h[15:0];
    endfunction

    assign o_pending = heading_q.size();

    // predict on input beats, compare on output beats
    always @(posedge i_clk) begin
        logic [15:0] exp_h;
        if (!i_rst_n) begin
            o_errors <= 0;
            o_headings_seen <= 0;
        end else begin
            if (i_valid && !i_stall_in)
                heading_q.push_back(predict_heading(i_field_x, i_field_y, i_field_z,
                                                    i_pitch_angle, i_roll_angle));
            if (i_out_valid && !i_out_stall) begin
                o_headings_seen <= o_headings_seen + 1;
                if (heading_q.size() == 0) begin
                    $display("%0t: heading beat with none expected, actual %0d",
                             $time, i_heading);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_h = heading_q.pop_front();
                    if (i_heading !== exp_h) begin
                        $display("%0t: heading mismatch, expected %0d actual %0d",
                                 $time, exp_h, i_heading);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end

endmodule

/* tb/tilt_compensated_heading_tb.sv */
`timescale 1ns / 100ps

module tilt_compensated_heading_tb import tch_pkg::*; ();

    localparam int RANDOM_BEATS = 900;
    localparam int LATENCY = 2 * CORDIC_STEPS + 12;
    localparam longint CYCLE_LIMIT = 400000;

    logic               clk, rst_n;
    logic               in_valid, in_stall, out_valid, out_stall;
    logic signed [15:0] fx, fy, fz, pitch, roll;
    logic [15:0]        heading;
    int                 errors, pending, headings_seen;
    int                 send_idle_pct, recv_idle_pct;
    longint             cycles;

    tilt_compensated_heading u_dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .o_stall(in_stall),
        .i_field_x(fx), .i_field_y(fy), .i_field_z(fz),
        .i_pitch_angle(pitch), .i_roll_angle(roll),
        .o_valid(out_valid), .i_stall(out_stall), .o_heading(heading)
    );

    tilt_compensated_heading_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .i_stall_in(in_stall),
        .i_field_x(fx), .i_field_y(fy), .i_field_z(fz),
        .i_pitch_angle(pitch), .i_roll_angle(roll),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_heading(heading),
        .o_errors(errors), .o_pending(pending), .o_headings_seen(headings_seen)
    );

    initial begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    // watchdog
    initial begin
        cycles = 0;
        forever begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // receiver stall
    always @(posedge clk) begin
        if (!rst_n) out_stall <= 1'b0;
        else out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    function automatic logic signed [15:0] rand_angle();
        case ($urandom_range(5))
            0: return 16'(int'($urandom_range(51472)) - 25736);
            1: return 16'(int'($urandom_range(12868)) - 6434);
            2: return 16'($urandom());  // full code range, beyond pi too
            default: return 16'(int'($urandom_range(6000)) - 3000);
        endcase
    endfunction

    function automatic logic signed [15:0] rand_field();
        case ($urandom_range(3))
            0: return 16'($urandom());
            1: return 16'(int'($urandom_range(1200)) - 600);
            2: return 16'(int'($urandom_range(8)) - 4);
            default: return 16'(int'($urandom_range(4096)) - 2048);
        endcase
    endfunction

    // one input beat; idles at random, then holds until accepted
    task automatic send_beat(input logic signed [15:0] x, y, z, p, r);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        fx <= x; fy <= y; fz <= z; pitch <= p; roll <= r;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++)
            send_beat(rand_field(), rand_field(), rand_field(), rand_angle(), rand_angle());
    endtask

    initial begin
        int guard;
        rst_n = 0; in_valid = 0;
        fx = 0; fy = 0; fz = 0; pitch = 0; roll = 0;
        send_idle_pct = 0; recv_idle_pct = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: zero vector, field extremes, cardinal directions, angle extremes
        send_beat(0, 0, 0, 0, 0);
        send_beat(0, 0, 16'sd1000, 0, 0);           // only vertical field, level
        send_beat(16'sd1000, 0, 0, 0, 0);
        send_beat(0, 16'sd1000, 0, 0, 0);
        send_beat(-16'sd1000, 0, 0, 0, 0);           // left half-plane
        send_beat(0, -16'sd1000, 0, 0, 0);
        send_beat(-16'sd1000, 16'sd1, 0, 0, 0);
        send_beat(-16'sd1000, -16'sd1, 0, 0, 0);
        send_beat(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 0, 0);
        send_beat(-16'sh8000, -16'sh8000, -16'sh8000, 0, 0);
        send_beat(16'sh7FFF, -16'sh8000, 16'sh7FFF, 16'sd25736, -16'sd25736);
        send_beat(-16'sh8000, 16'sh7FFF, -16'sh8000, -16'sd25736, 16'sd25736);
        send_beat(16'sd500, 16'sd300, 16'sd200, 16'sd12868, 16'sd12868);   // about pi/2
        send_beat(16'sd500, 16'sd300, 16'sd200, 16'sd12869, -16'sd12869);  // past quarter turn
        send_beat(16'sd500, -16'sd300, 16'sd200, -16'sd12868, 16'sd20000);
        send_beat(16'sd700, 16'sd100, -16'sd400, 16'sh7FFF, -16'sh8000);    // beyond pi
        send_beat(-16'sd700, 16'sd100, 16'sd400, -16'sh8000, 16'sh7FFF);
        send_beat(16'sd1, 0, 0, 0, 0);
        send_beat(-16'sd1, -16'sd1, 16'sd1, 16'sd1, -16'sd1);
        send_beat(16'sd1, 16'sd1, 16'sd1, 16'sd3000, 16'sd3000);

        // random, three idling phases
        send_idle_pct = 24; recv_idle_pct = 72;
        send_random(RANDOM_BEATS / 3);
        send_idle_pct = 72; recv_idle_pct = 24;
        send_random(RANDOM_BEATS / 3);
        send_idle_pct = 0; recv_idle_pct = 0;
        send_random(RANDOM_BEATS / 3);
        in_valid <= 1'b0;

        guard = 0;
        while (pending != 0 && guard < 100000) begin
            @(posedge clk);
            guard++;
        end
        repeat (LATENCY + 10) @(posedge clk);

        $display("Covered %0d heading beats: zero vector, field and angle extremes,",
                 headings_seen);
        $display("all quadrants, angles beyond quarter and half turn, random stalls.");
        if (errors == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
